@@ rtl/time_of_day_clock_macros.svh @@
// Assertion macros for the time-of-day clock checker.
// Expects signals named clock and reset in the scope of use.
`ifndef TIME_OF_DAY_CLOCK_MACROS_SVH
`define TIME_OF_DAY_CLOCK_MACROS_SVH

// Clocked assertion, off while reset is high.
`define TOD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define TOD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/tod_pkg.sv @@
// Shared types, constants and helper functions for the time-of-day clock.
// No dependencies.
`default_nettype none

package tod_pkg;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_LOAD = 1'b1
   } command_type;

   typedef struct packed {
      command_type command;
      logic [9:0]  tick_ms;
      logic [7:0]  load_hour;
      logic [7:0]  load_minute;
      logic [7:0]  load_second;
      logic        load_binary;
   } req_type;

   typedef struct packed {
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  second;
      logic [19:0] seconds_of_day;
      logic [63:0] elapsed_ms;
      logic        second_carry;
   } rsp_type;

   localparam logic [9:0]  MS_PER_SECOND   = 10'd1000;
   localparam logic [9:0]  MAX_DELTA_MS    = 10'd999;
   localparam logic [7:0]  SEC_PER_MIN     = 8'd60;
   localparam logic [7:0]  MIN_PER_HOUR    = 8'd60;
   localparam logic [19:0] SOD_PER_HOUR    = 20'd3600;
   localparam logic [19:0] SOD_PER_MIN     = 20'd60;
   localparam logic [7:0]  BCD_TEN         = 8'd10;

   // low nibble plus ten times high nibble
   function automatic logic [7:0] bcd_decode(input logic [7:0] v);
      logic [7:0] tens;
      tens = 8'(v[7:4] * BCD_TEN);
      return tens + {4'd0, v[3:0]};
   endfunction

   // x mod 24 for x up to 511: (x / 8) mod 3 gives the upper two bits
   function automatic logic [7:0] mod24(input logic [8:0] x);
      logic [3:0] dsum;
      logic [3:0] r;
      dsum = {2'd0, x[4:3]} + {2'd0, x[6:5]} + {2'd0, x[8:7]};
      if (dsum >= 4'd9) begin
         r = dsum - 4'd9;
      end else if (dsum >= 4'd6) begin
         r = dsum - 4'd6;
      end else if (dsum >= 4'd3) begin
         r = dsum - 4'd3;
      end else begin
         r = dsum;
      end
      return {3'd0, r[1:0], x[2:0]};
   endfunction

endpackage

`default_nettype wire

@@ rtl/tod_core.sv @@
// Time-of-day state registers and the combinational update logic.
// Depends on tod_pkg.
`default_nettype none

module tod_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire tod_pkg::req_type req,
   output tod_pkg::rsp_type      rsp
);

   logic [9:0]  sub_ms_ff, sub_ms_in;
   logic [7:0]  hour_ff, hour_in;
   logic [7:0]  minute_ff, minute_in;
   logic [7:0]  second_ff, second_in;
   logic [63:0] ms_count_ff, ms_count_in;

   logic [9:0]  delta_sat;
   logic [10:0] sub_sum;
   logic        carry;
   logic [7:0]  sec_inc;
   logic [7:0]  min_inc;
   logic        sec_wrap;
   logic        min_wrap;

   always_comb begin
      delta_sat = (req.tick_ms > tod_pkg::MAX_DELTA_MS) ? tod_pkg::MAX_DELTA_MS : req.tick_ms;
      sub_sum   = {1'b0, sub_ms_ff} + {1'b0, delta_sat};
      carry     = (sub_sum >= {1'b0, tod_pkg::MS_PER_SECOND});
      sec_inc   = second_ff + 8'd1;
      min_inc   = minute_ff + 8'd1;
      sec_wrap  = carry && (sec_inc >= tod_pkg::SEC_PER_MIN);
      min_wrap  = sec_wrap && (min_inc >= tod_pkg::MIN_PER_HOUR);

      if (req.command == tod_pkg::CMD_LOAD) begin
         if (req.load_binary) begin
            hour_in   = req.load_hour;
            minute_in = req.load_minute;
            second_in = req.load_second;
         end else begin
            hour_in   = tod_pkg::bcd_decode(req.load_hour);
            minute_in = tod_pkg::bcd_decode(req.load_minute);
            second_in = tod_pkg::bcd_decode(req.load_second);
         end
         sub_ms_in   = '0;
         ms_count_in = '0;
      end else begin
         sub_ms_in   = carry ? 10'(sub_sum - {1'b0, tod_pkg::MS_PER_SECOND}) : sub_sum[9:0];
         ms_count_in = ms_count_ff + {54'd0, delta_sat};
         second_in   = carry ? (sec_wrap ? 8'd0 : sec_inc) : second_ff;
         minute_in   = sec_wrap ? (min_wrap ? 8'd0 : min_inc) : minute_ff;
         hour_in     = min_wrap ? tod_pkg::mod24({1'b0, hour_ff} + 9'd1) : hour_ff;
      end

      rsp.hour           = hour_in;
      rsp.minute         = minute_in;
      rsp.second         = second_in;
      rsp.seconds_of_day = 20'(hour_in) * tod_pkg::SOD_PER_HOUR
                         + 20'(minute_in) * tod_pkg::SOD_PER_MIN
                         + 20'(second_in);
      rsp.elapsed_ms     = ms_count_in;
      rsp.second_carry   = (req.command == tod_pkg::CMD_TICK) && carry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ms_ff   <= '0;
         hour_ff     <= '0;
         minute_ff   <= '0;
         second_ff   <= '0;
         ms_count_ff <= '0;
      end else if (advance) begin
         sub_ms_ff   <= sub_ms_in;
         hour_ff     <= hour_in;
         minute_ff   <= minute_in;
         second_ff   <= second_in;
         ms_count_ff <= ms_count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/time_of_day_clock.sv @@
// Time-of-day clock top level: request register, update core, response register.
// Depends on tod_pkg and tod_core.
// The request register and the response register lie between request acceptance and rsp_valid;
// throughput 1 request per cycle while rsp_stall does not hold the response register.
// Synchronous reset clears time, sub-second accumulator, elapsed count and both valid flags.
`default_nettype none

module time_of_day_clock (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire tod_pkg::req_type req,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      tod_pkg::rsp_type rsp
);

   logic             s1_valid_ff, s1_valid_in;
   tod_pkg::req_type s1_req_ff, s1_req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tod_pkg::rsp_type rsp_ff, rsp_in;
   tod_pkg::rsp_type core_rsp;
   logic             out_free;
   logic             advance;

   tod_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (s1_req_ff),
      .rsp     (core_rsp)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      advance      = s1_valid_ff && out_free;
      req_stall    = s1_valid_ff && !out_free;
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
      s1_req_in    = (req_valid && !req_stall) ? req : s1_req_ff;
      rsp_valid_in = out_free ? advance : rsp_valid_ff;
      rsp_in       = advance ? core_rsp : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/tod_checker.sv @@
// Port-level assertions for the time-of-day clock, bound to the top level.
// Depends on tod_pkg and time_of_day_clock_macros.svh.
`default_nettype none
`include "time_of_day_clock_macros.svh"

module tod_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire tod_pkg::req_type req,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire tod_pkg::rsp_type rsp
);

   logic        req_seen;
   logic        rsp_held;
   logic        carry_seen;
   logic [19:0] sod_check;

   assign req_seen   = req_valid && !req_stall;
   assign rsp_held   = rsp_valid && rsp_stall;
   assign carry_seen = rsp_valid && rsp.second_carry;
   assign sod_check  = 20'(rsp.hour) * tod_pkg::SOD_PER_HOUR
                     + 20'(rsp.minute) * tod_pkg::SOD_PER_MIN + 20'(rsp.second);

   `TOD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid right after reset")
   `TOD_ASSERT(a_rsp_hold, rsp_held |=> rsp_valid && $stable(rsp), "stalled response changed")
   `TOD_ASSERT(a_carry_second, carry_seen |-> rsp.second < 8'd60, "second past 59 on carry")
   `TOD_ASSERT(a_sod, rsp_valid |-> rsp.seconds_of_day == sod_check, "seconds of day mismatch")
   `TOD_ASSERT(a_no_spurious, !req_seen ##1 !rsp_valid |=> !rsp_valid, "response without request")

endmodule

bind time_of_day_clock tod_checker u_tod_checker (.*);

`default_nettype wire

@@ test/time_of_day_clock_checker.sv @@
`timescale 1ns / 100ps
// Checker for the time-of-day clock: watches both channels, predicts each response
// from accepted requests and compares field by field. Depends on tod_pkg.

module time_of_day_clock_checker (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire tod_pkg::req_type req,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire tod_pkg::rsp_type rsp,
   output int                    failures,
   output int                    pending
);

   logic [7:0]       cur_hour;
   logic [7:0]       cur_minute;
   logic [7:0]       cur_second;
   logic [9:0]       acc_ms;
   logic [63:0]      ms_since_load;
   tod_pkg::rsp_type expected_times[$];

   initial begin
      failures = 0;
      pending  = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      failures++;
   endtask

   function automatic logic [7:0] bcd_value(input logic [7:0] raw);
      return 8'(raw[7:4] * 10) + {4'd0, raw[3:0]};
   endfunction

   // applies one request to the predicted clock and returns the response it gives
   function automatic tod_pkg::rsp_type advance_time_of_day(input tod_pkg::req_type r);
      tod_pkg::rsp_type out;
      int               sum;
      logic [9:0]       delta;
      out = '0;
      if (r.command == tod_pkg::CMD_LOAD) begin
         if (r.load_binary) begin
            cur_hour   = r.load_hour;
            cur_minute = r.load_minute;
            cur_second = r.load_second;
         end else begin
            cur_hour   = bcd_value(r.load_hour);
            cur_minute = bcd_value(r.load_minute);
            cur_second = bcd_value(r.load_second);
         end
         acc_ms        = '0;
         ms_since_load = '0;
      end else begin
         delta = (r.tick_ms > 10'd999) ? 10'd999 : r.tick_ms;
         ms_since_load = ms_since_load + 64'(delta);
         sum = int'(acc_ms) + int'(delta);
         if (sum >= 1000) begin
            sum -= 1000;
            out.second_carry = 1'b1;
            cur_second = cur_second + 8'd1;
            if (cur_second >= 8'd60) begin
               cur_second = '0;
               cur_minute = cur_minute + 8'd1;
               if (cur_minute >= 8'd60) begin
                  cur_minute = '0;
                  cur_hour   = 8'((int'(cur_hour) + 1) % 24);
               end
            end
         end
         acc_ms = 10'(sum);
      end
      out.hour           = cur_hour;
      out.minute         = cur_minute;
      out.second         = cur_second;
      out.seconds_of_day = 20'(int'(cur_hour) * 3600 + int'(cur_minute) * 60 + int'(cur_second));
      out.elapsed_ms     = ms_since_load;
      return out;
   endfunction

   always @(posedge clock) begin : watch
      tod_pkg::rsp_type want;
      if (reset) begin
         cur_hour      = '0;
         cur_minute    = '0;
         cur_second    = '0;
         acc_ms        = '0;
         ms_since_load = '0;
         expected_times.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_times.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_times.pop_front();
               if (rsp.hour !== want.hour)
                  report_mismatch($sformatf("hour %0d, want %0d", rsp.hour, want.hour));
               if (rsp.minute !== want.minute)
                  report_mismatch($sformatf("minute %0d, want %0d", rsp.minute, want.minute));
               if (rsp.second !== want.second)
                  report_mismatch($sformatf("second %0d, want %0d", rsp.second, want.second));
               if (rsp.seconds_of_day !== want.seconds_of_day)
                  report_mismatch($sformatf("seconds_of_day %0d, want %0d",
                                            rsp.seconds_of_day, want.seconds_of_day));
               if (rsp.elapsed_ms !== want.elapsed_ms)
                  report_mismatch($sformatf("elapsed_ms %0d, want %0d",
                                            rsp.elapsed_ms, want.elapsed_ms));
               if (rsp.second_carry !== want.second_carry)
                  report_mismatch($sformatf("second_carry %0b, want %0b",
                                            rsp.second_carry, want.second_carry));
            end
         end
         if (req_valid && !req_stall) begin
            expected_times.push_back(advance_time_of_day(req));
         end
      end
      pending = expected_times.size();
   end

endmodule

@@ test/time_of_day_clock_tb.sv @@
`timescale 1ns / 100ps
// Top of the time-of-day clock testbench: clock, reset, request and response drivers.
// Depends on tod_pkg, time_of_day_clock and time_of_day_clock_checker.

module time_of_day_clock_tb;

   localparam int ITEM_COUNT  = 1350;
   localparam int HOLD_CYCLES = 200;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REQ_BITS    = $bits(tod_pkg::req_type);

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   tod_pkg::req_type req;
   logic             rsp_valid;
   logic             rsp_stall;
   tod_pkg::rsp_type rsp;
   int               failures;
   int               pending;
   int               cycles = 0;
   bit               gaps_on = 1'b1;
   bit               hold_off_now = 1'b0;

   time_of_day_clock dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   time_of_day_clock_checker tod_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("time_of_day_clock_tb failed");
         $finish;
      end
   end

   function automatic logic [7:0] to_bcd(input int v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic tod_pkg::req_type tick_request(input logic [9:0] delta);
      tod_pkg::req_type r;
      r = tod_pkg::req_type'(REQ_BITS'({$urandom, $urandom}));
      r.command = tod_pkg::CMD_TICK;
      r.tick_ms = delta;
      return r;
   endfunction

   function automatic tod_pkg::req_type load_request(input bit binary, input logic [7:0] h,
                                                     input logic [7:0] m, input logic [7:0] s);
      tod_pkg::req_type r;
      r = tod_pkg::req_type'(REQ_BITS'({$urandom, $urandom}));
      r.command     = tod_pkg::CMD_LOAD;
      r.load_binary = binary;
      r.load_hour   = h;
      r.load_minute = m;
      r.load_second = s;
      return r;
   endfunction

   function automatic tod_pkg::req_type random_tick();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return tick_request(10'($urandom_range(1000, 1023)));
      if (pick < 25) return tick_request(10'($urandom_range(990, 999)));
      if (pick < 30) return tick_request(10'd0);
      return tick_request(10'($urandom_range(0, 999)));
   endfunction

   // mostly legal times close to a rollover, some raw bytes
   function automatic tod_pkg::req_type random_load();
      int pick;
      int h;
      int m;
      int s;
      bit binary;
      pick   = $urandom_range(0, 99);
      binary = 1'($urandom);
      if (pick < 15) begin
         return load_request(binary, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      h = (pick < 40) ? 23 : $urandom_range(0, 23);
      m = (pick < 65) ? 59 : $urandom_range(0, 59);
      s = (pick < 80) ? $urandom_range(55, 59) : $urandom_range(0, 59);
      if (binary) return load_request(1'b1, 8'(h), 8'(m), 8'(s));
      return load_request(1'b0, to_bcd(h), to_bcd(m), to_bcd(s));
   endfunction

   // entered and left at a falling edge; valid stays high on return
   task automatic send_request(input tod_pkg::req_type r);
      int gap;
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req       <= r;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   initial begin : receiver
      int w;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         w = gaps_on ? $urandom_range(0, 7) : 0;
         if (hold_off_now) begin
            hold_off_now = 1'b0;
            w = HOLD_CYCLES;
         end
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int n;
      req_valid = 1'b0;
      req       = '0;
      reset     = 1'b1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // BCD load, midnight rollover, oversized deltas
      send_request(load_request(1'b0, 8'h23, 8'h59, 8'h58));
      send_request(tick_request(10'd999));
      send_request(tick_request(10'd1));
      send_request(tick_request(10'd1000));
      send_request(tick_request(10'd1023));
      send_request(tick_request(10'd0));
      send_request(load_request(1'b1, 8'd23, 8'd59, 8'd59));
      send_request(tick_request(10'd1023));
      send_request(tick_request(10'd999));
      // invalid BCD digits
      send_request(load_request(1'b0, 8'hFF, 8'hFF, 8'hFF));
      send_request(tick_request(10'd999));
      send_request(tick_request(10'd1));
      // binary extremes: largest seconds of day, hour past 24
      send_request(load_request(1'b1, 8'd255, 8'd255, 8'd255));
      send_request(load_request(1'b1, 8'd255, 8'd59, 8'd59));
      send_request(tick_request(10'd999));
      send_request(tick_request(10'd1));
      // minute and second wrapping through 8 bits
      send_request(load_request(1'b1, 8'd5, 8'd255, 8'd59));
      send_request(tick_request(10'd999));
      send_request(tick_request(10'd1));
      send_request(load_request(1'b1, 8'd1, 8'd2, 8'd255));
      send_request(tick_request(10'd500));
      send_request(tick_request(10'd500));
      send_request(load_request(1'b0, 8'h00, 8'h00, 8'h00));
      send_request(tick_request(10'd1000));
      drain();

      for (n = 0; n < ITEM_COUNT; n++) begin
         if (n == 300) hold_off_now = 1'b1;
         if (n == 700) drain();
         gaps_on = !((n >= 500 && n < 650) || (n >= 1000 && n < 1100));
         if ($urandom_range(0, 99) < 12) begin
            send_request(random_load());
         end else begin
            send_request(random_tick());
         end
      end
      gaps_on = 1'b1;
      drain();
      repeat (8) @(negedge clock);
      if (failures == 0) begin
         $display("time_of_day_clock_tb passed");
      end else begin
         $display("time_of_day_clock_tb failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tod_pkg.sv
rtl/tod_core.sv
rtl/time_of_day_clock.sv
rtl/tod_checker.sv
test/time_of_day_clock_checker.sv
test/time_of_day_clock_tb.sv
